[sv/pbfe_pkg.sv]
package pbfe_pkg;

	// operation codes carried in s_tuser
	typedef enum logic [1:0] {
		OP_FIELD = 2'd0,
		OP_LEN   = 2'd1,
		OP_RAW   = 2'd2,
		OP_BARE  = 2'd3
	} op_t;

	localparam int TAG_NUM_W = 29;
	localparam int VALUE_W   = 64;
	localparam int TAG_W     = TAG_NUM_W + 3;
	localparam int COUNT_W   = 32;

	localparam logic [2:0] WIRE_VARINT = 3'd0;
	localparam logic [2:0] WIRE_LEN    = 3'd2;

	localparam int QUEUE_DEPTH = 2;

	// one classified item waiting for the serializer
	typedef struct packed {
		logic               has_tag;
		logic               raw;
		logic [TAG_W-1:0]   tag_word;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TAG,
		ST_VAL
	} ser_state_t;

endpackage

[sv/pbfe_front.sv]
module pbfe_front (
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [1:0]                       s_tuser,
	input  logic [pbfe_pkg::TAG_NUM_W-1:0]   tag_num,
	input  logic [pbfe_pkg::VALUE_W-1:0]     value,
	input  pbfe_pkg::q_stat_t                q_stat,
	output logic                             push,
	output pbfe_pkg::cmd_t                   cmd
);

	pbfe_pkg::op_t op;

	assign op       = pbfe_pkg::op_t'(s_tuser);
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && !q_stat.full;

	always_comb begin
		cmd.value    = value;
		cmd.has_tag  = 1'b0;
		cmd.raw      = 1'b0;
		cmd.tag_word = {tag_num, pbfe_pkg::WIRE_VARINT};
		unique case (op)
			pbfe_pkg::OP_FIELD: begin
				cmd.has_tag = 1'b1;
			end
			pbfe_pkg::OP_LEN: begin
				cmd.has_tag  = 1'b1;
				cmd.tag_word = {tag_num, pbfe_pkg::WIRE_LEN};
			end
			pbfe_pkg::OP_RAW: begin
				cmd.raw = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

[sv/pbfe_queue.sv]
module pbfe_queue #(
	parameter int DEPTH = pbfe_pkg::QUEUE_DEPTH	// 2 and up
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pbfe_pkg::cmd_t    wr_cmd,
	input  logic              pop,
	output pbfe_pkg::cmd_t    rd_cmd,
	output pbfe_pkg::q_stat_t stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pbfe_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign stat.full  = (cnt_q == FULL_CNT);
	assign stat.empty = (cnt_q == '0);
	assign rd_cmd     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[sv/pbfe_back.sv]
module pbfe_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           count_only,
	input  pbfe_pkg::cmd_t                 cmd,
	input  pbfe_pkg::q_stat_t              q_stat,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     out_byte,
	output logic                           sent,
	output logic                           last,
	output logic [pbfe_pkg::COUNT_W-1:0]   byte_count
);

	pbfe_pkg::ser_state_t state_q, state_d;

	logic [pbfe_pkg::TAG_W-1:0]   tag_q;
	logic [pbfe_pkg::VALUE_W-1:0] val_q;
	logic                         raw_q;
	logic [pbfe_pkg::COUNT_W-1:0] count_q;
	logic                         ovalid_q;

	logic       slot_free;
	logic       emit;
	logic       tag_more, val_more;
	logic [7:0] byte_d;
	logic       last_d;

	assign slot_free = !ovalid_q || m_tready;
	assign tag_more  = |tag_q[pbfe_pkg::TAG_W-1:7];
	assign val_more  = |val_q[pbfe_pkg::VALUE_W-1:7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pbfe_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		byte_d  = {1'b0, val_q[6:0]};
		last_d  = 1'b0;
		unique case (state_q)
			pbfe_pkg::ST_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = cmd.has_tag ? pbfe_pkg::ST_TAG : pbfe_pkg::ST_VAL;
				end
			end
			pbfe_pkg::ST_TAG: begin
				byte_d = {tag_more, tag_q[6:0]};
				if (slot_free) begin
					emit = 1'b1;
					if (!tag_more)
						state_d = pbfe_pkg::ST_VAL;
				end
			end
			pbfe_pkg::ST_VAL: begin
				if (raw_q) begin
					byte_d = val_q[7:0];
					last_d = 1'b1;
				end else begin
					byte_d = {val_more, val_q[6:0]};
					last_d = !val_more;
				end
				if (slot_free) begin
					emit = 1'b1;
					if (last_d)
						state_d = pbfe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pbfe_pkg::ST_IDLE;
			end
		endcase
	end

	// operand shifters, 7 bits per emitted byte
	always_ff @(posedge clk) begin
		if (pop) begin
			tag_q <= cmd.tag_word;
			val_q <= cmd.value;
			raw_q <= cmd.raw;
		end else if (emit) begin
			if (state_q == pbfe_pkg::ST_TAG)
				tag_q <= tag_q >> 7;
			else
				val_q <= val_q >> 7;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte <= byte_d;
			sent     <= !count_only;
			last     <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (emit) begin
				count_q  <= count_q + 1'b1;
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid   = ovalid_q;
	assign byte_count = count_q;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> count_q == $past(count_q) + 1'b1)
		else $error("byte count did not advance on emitted byte");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == pbfe_pkg::ST_IDLE && !q_stat.empty)
		else $error("queue popped outside idle or while empty");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !ovalid_q || m_tready)
		else $error("output register overwritten while held");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!emit |=> $stable(count_q))
		else $error("byte count moved without emitted byte");

endmodule

[sv/protobuf_field_encoder.sv]
// Protocol buffer field encoder.
// Input stream (s_*): one beat per operation. s_tuser carries the op code
// (field varint, length-delimited header, raw byte, bare varint); s_tdata
// carries tag_num and value. Output stream (m_*): one beat per encoded byte,
// with m_tlast on the final byte of an operation, m_tuser as the sent flag
// and the 32-bit running byte count next to the byte in m_tdata.
// Config channel (cfg_*): one bit, count_only; when set, bytes are still
// produced and counted but flagged unsent. Write it only while idle.
// Timing: the front classifies and pushes into a small queue in the beat
// cycle; the back sequencer pops an operation while idle, then emits one byte
// per cycle through a registered output while m_tready does not stall it. An
// operation yields 1 to 15 bytes; the sequencer pops the next operation only
// after the last byte of the current one, while the queue keeps taking beats.
// Reset clears the byte count, count_only, the queue and the output valid flag.
// A stalled m_tready holds the output beat; the sequencer then waits and the
// queue fills, after which s_tready drops.
module protobuf_field_encoder #(
	parameter int QUEUE_DEPTH = pbfe_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,	// [28:0] tag_num, [92:29] value, [95:93] zero
	input  logic [1:0]  s_tuser,	// [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,	// [7:0] out_byte, [39:8] byte_count
	output logic        m_tuser,	// [0] sent
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data	// count_only
);

	pbfe_pkg::cmd_t    fr_cmd, q_cmd;
	pbfe_pkg::q_stat_t q_stat;
	logic              push, pop;
	logic              count_only_q;
	logic [7:0]        out_byte;
	logic [31:0]       byte_count;

	// register write always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_only_q <= 1'b0;
		else if (cfg_valid)
			count_only_q <= cfg_data;
	end

	pbfe_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.tag_num  (s_tdata[28:0]),
		.value    (s_tdata[92:29]),
		.q_stat   (q_stat),
		.push     (push),
		.cmd      (fr_cmd)
	);

	pbfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (fr_cmd),
		.pop    (pop),
		.rd_cmd (q_cmd),
		.stat   (q_stat)
	);

	pbfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.count_only (count_only_q),
		.cmd        (q_cmd),
		.q_stat     (q_stat),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_byte   (out_byte),
		.sent       (m_tuser),
		.last       (m_tlast),
		.byte_count (byte_count)
	);

	assign m_tdata = {byte_count, out_byte};

endmodule

[verif/tb.sv]
module tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 400;	// long receiver hold-off
	localparam int unsigned SETTLE      = 16;	// idle cycles after the last byte

	// one operation as offered on the input stream
	typedef struct {
		pbfe_pkg::op_t op;
		logic [28:0]   tag_num;
		logic [63:0]   value;
	} pb_op_t;

	// one encoded byte as expected on the output stream
	typedef struct {
		logic [7:0]  out_byte;
		logic        sent;
		logic        last;
		logic [31:0] byte_count;
	} pb_byte_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata   = '0;	// [28:0] tag_num, [92:29] value, [95:93] zero
	logic [1:0]  s_tuser   = '0;	// [1:0] op
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;		// [7:0] out_byte, [39:8] byte_count
	logic        m_tuser;		// [0] sent
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data  = 1'b0;	// count_only

	// shadow of the block: running byte count and the count-only flag
	logic [31:0] shadow_byte_total = '0;
	logic        shadow_count_only = 1'b0;

	pb_op_t      op_backlog[$];		// operations waiting to be offered
	pb_byte_t    byte_expect_q[$];	// encoded bytes still owed by the block
	logic [7:0]  enc_bytes[$];		// scratch: bytes of the op being encoded
	pb_op_t      in_flight;		// op currently on s_tdata/s_tuser
	pb_op_t      nxt_op;
	pb_byte_t    want;

	int unsigned ops_queued   = 0;
	int unsigned ops_accepted = 0;
	int unsigned mismatches   = 0;
	int unsigned cycle_cnt    = 0;
	int unsigned gap_left     = 0;
	int unsigned stall_left   = 0;
	int unsigned hold_left    = 0;
	logic        hold_req     = 1'b0;
	logic        hold_used    = 1'b0;
	logic        quiet        = 1'b0;	// no idling on either side

	protobuf_field_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Encoder prediction
	// ------------------------------------------------------------------

	// Varint: 7 bits per byte, low group first, bit 7 set on all but the last.
	function automatic void push_varint(logic [63:0] v);
		while (v > 64'h7F) begin
			enc_bytes.push_back({1'b1, v[6:0]});
			v = v >> 7;
		end
		enc_bytes.push_back({1'b0, v[6:0]});
	endfunction

	// Encodes one accepted op and queues its bytes; every op yields >= 1 byte.
	function automatic void encode_op(pb_op_t it);
		pb_byte_t e;
		enc_bytes.delete();
		case (it.op)
			pbfe_pkg::OP_FIELD: begin
				push_varint({32'd0, it.tag_num, pbfe_pkg::WIRE_VARINT});
				push_varint(it.value);
			end
			pbfe_pkg::OP_LEN: begin
				push_varint({32'd0, it.tag_num, pbfe_pkg::WIRE_LEN});
				push_varint(it.value);
			end
			pbfe_pkg::OP_RAW: enc_bytes.push_back(it.value[7:0]);	// tag and upper value ignored
			default: push_varint(it.value);		// bare varint, tag ignored
		endcase
		foreach (enc_bytes[i]) begin
			shadow_byte_total = shadow_byte_total + 32'd1;	// wraps at 32 bits
			e.out_byte   = enc_bytes[i];
			e.sent       = !shadow_count_only;
			e.last       = (i == enc_bytes.size() - 1);
			e.byte_count = shadow_byte_total;
			byte_expect_q.push_back(e);
		end
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
		$display("t=%0t %s: expected %0h, got %0h", $time, what, exp_v, got_v);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Input driver: one op per beat, random gap bursts unless quiet.
	// An op is predicted at the edge where its beat is taken.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				encode_op(in_flight);
				ops_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (!quiet && op_backlog.size() != 0 && $urandom_range(0, 7) == 0) begin
					// start a gap burst
					gap_left <= $urandom_range(0, 11);
					s_tvalid <= 1'b0;
				end else if (op_backlog.size() != 0) begin
					nxt_op = op_backlog.pop_front();
					in_flight <= nxt_op;
					s_tdata   <= {3'b000, nxt_op.value, nxt_op.tag_num};
					s_tuser   <= nxt_op.op;
					s_tvalid  <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here; armed once by the sequence below.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Output monitor: checks each taken beat against the oldest expected
	// byte, and drives m_tready with random stall bursts.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (byte_expect_q.size() == 0) begin
					flag_mismatch("beat with nothing expected", 64'd0,
						{22'd0, m_tlast, m_tuser, m_tdata});
				end else begin
					want = byte_expect_q.pop_front();
					if (m_tdata[7:0] !== want.out_byte)
						flag_mismatch("out_byte", 64'(want.out_byte), 64'(m_tdata[7:0]));
					if (m_tdata[39:8] !== want.byte_count)
						flag_mismatch("byte_count", 64'(want.byte_count),
							64'(m_tdata[39:8]));
					if (m_tuser !== want.sent)
						flag_mismatch("sent", 64'(want.sent), 64'(m_tuser));
					if (m_tlast !== want.last)
						flag_mismatch("last", 64'(want.last), 64'(m_tlast));
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 11);
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence helpers
	// ------------------------------------------------------------------

	task automatic queue_op(pbfe_pkg::op_t op, logic [28:0] tag_num, logic [63:0] value);
		pb_op_t it;
		it.op      = op;
		it.tag_num = tag_num;
		it.value   = value;
		op_backlog.push_back(it);
		ops_queued++;
	endtask

	// Value with a random number of significant bits, so every varint
	// length from 1 to 10 bytes comes up.
	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		int unsigned k;
		v = {$urandom(), $urandom()};
		k = $urandom_range(0, 64);
		if (k == 0)
			return 64'd0;
		v = v >> (64 - k);
		if ($urandom_range(0, 1) == 1)
			v[k-1] = 1'b1;
		return v;
	endfunction

	function automatic logic [28:0] rand_tag();
		logic [28:0] t;
		int unsigned k;
		t = 29'($urandom());
		k = $urandom_range(0, 29);
		if (k == 0)
			return 29'd0;
		return t >> (29 - k);
	endfunction

	task automatic queue_random(int unsigned n);
		repeat (n)
			queue_op(pbfe_pkg::op_t'($urandom_range(0, 3)), rand_tag(), rand_value());
	endtask

	// Sender pause: wait until every queued op is taken and every expected
	// byte has come out, then let the pipeline drain.
	task automatic run_to_idle();
		do
			@(posedge clk);
		while (ops_accepted != ops_queued || byte_expect_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// count_only write; only called with the block idle
	task automatic write_mode(logic count_only);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= count_only;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_count_only = count_only;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_mode(1'b0);

		// directed: extremes and varint length boundaries
		queue_op(pbfe_pkg::OP_FIELD, 29'd0, 64'd0);
		queue_op(pbfe_pkg::OP_FIELD, '1, '1);			// 5 + 10 bytes, the longest op
		queue_op(pbfe_pkg::OP_FIELD, 29'd15, 64'd127);	// one-byte tag, one-byte value
		queue_op(pbfe_pkg::OP_FIELD, 29'd16, 64'd128);	// both just spill into two bytes
		queue_op(pbfe_pkg::OP_FIELD, 29'h1000_0000, 64'd300);	// tag bit 31 set: 5-byte tag
		queue_op(pbfe_pkg::OP_LEN, 29'd1, 64'd0);
		queue_op(pbfe_pkg::OP_LEN, '1, 64'h8000_0000_0000_0000);
		queue_op(pbfe_pkg::OP_LEN, 29'd2047, 64'd16383);
		queue_op(pbfe_pkg::OP_LEN, 29'd2048, 64'd16384);
		queue_op(pbfe_pkg::OP_RAW, '1, 64'hFFFF_FFFF_FFFF_FF5A);	// tag and high bits ignored
		queue_op(pbfe_pkg::OP_RAW, 29'd0, 64'd0);
		queue_op(pbfe_pkg::OP_RAW, 29'd0, 64'hFF);
		queue_op(pbfe_pkg::OP_BARE, '1, 64'd0);		// tag ignored
		queue_op(pbfe_pkg::OP_BARE, 29'd0, '1);
		queue_op(pbfe_pkg::OP_BARE, 29'd0, 64'h8000_0000_0000_0000);
		queue_op(pbfe_pkg::OP_BARE, 29'd0, 64'h00FF_FFFF_FFFF_FFFF);	// 8 bytes
		queue_op(pbfe_pkg::OP_BARE, 29'd0, 64'h0100_0000_0000_0000);	// 9 bytes
		run_to_idle();

		// count-only: bytes still produced and counted, flagged unsent
		write_mode(1'b1);
		queue_op(pbfe_pkg::OP_FIELD, '1, '1);
		queue_op(pbfe_pkg::OP_RAW, 29'd0, 64'hFF);
		queue_op(pbfe_pkg::OP_BARE, 29'd0, 64'd0);
		queue_op(pbfe_pkg::OP_LEN, 29'd1, 64'd5);
		queue_random(60);
		run_to_idle();

		// back to sending; receiver holds off while the sender keeps
		// offering, so the internal queue fills and s_tready drops
		write_mode(1'b0);
		queue_random(150);
		hold_req <= 1'b1;
		run_to_idle();

		write_mode(1'b1);
		queue_random(50);
		run_to_idle();

		// last stretch at full rate, no idling on either side
		write_mode(1'b0);
		quiet <= 1'b1;
		queue_random(90);
		run_to_idle();

		if (mismatches == 0 && byte_expect_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
sv/pbfe_pkg.sv
sv/pbfe_front.sv
sv/pbfe_queue.sv
sv/pbfe_back.sv
sv/protobuf_field_encoder.sv
verif/tb.sv
